// ----- rtl/linear_interp_resampler_defines.svh -----
// ---------------------------------------------------------------------------
// linear_interp_resampler_defines.svh
// Assertion macros shared by the resampler's checker.
// ---------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LIRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lirs: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LIRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lirs: check failed");

// Next-cycle implication that also runs through reset.
`define LIRS_ASSERT_NXT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lirs: reset check failed");

`endif

// ----- rtl/lirs_pkg.sv -----
// ---------------------------------------------------------------------------
// lirs_pkg
// Types, constants and helpers of the linear interpolation resampler.
// ---------------------------------------------------------------------------
package lirs_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned PHASE_W  = 21;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam logic [PHASE_W-1:0] ONE_Q16    = 21'h10000;
  localparam logic [PHASE_W-1:0] STEP_MIN   = 21'd1024;
  localparam logic [PHASE_W-1:0] STEP_MAX   = 21'd1048576;
  localparam logic [PHASE_W-1:0] STEP_RESET = 21'h10000;

  // Register index, taken from paddr bit 2 (word addressing).
  localparam logic REG_STEP = 1'b0;
  localparam logic REG_MONO = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Control from the sequencer to a bit-serial multiply unit.
  typedef struct packed {
    logic start;
    logic shift;
  } mac_ctrl_t;

  function automatic logic [PHASE_W-1:0] clamp_step(input logic [PHASE_W-1:0] v);
    logic [PHASE_W-1:0] r;
    r = v;
    if (v < STEP_MIN) r = STEP_MIN;
    if (v > STEP_MAX) r = STEP_MAX;
    return r;
  endfunction

endpackage

// ----- rtl/lirs_in_if.sv -----
// ---------------------------------------------------------------------------
// lirs_in_if
// Source frame channel: valid/ready with a stereo sample pair per beat.
// ---------------------------------------------------------------------------
interface lirs_in_if import lirs_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ----- rtl/lirs_out_if.sv -----
// ---------------------------------------------------------------------------
// lirs_out_if
// Output frame channel: valid/ready with an interpolated pair per beat.
// ---------------------------------------------------------------------------
interface lirs_out_if import lirs_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t out_left;
  sample_t out_right;
  logic    last_of_run;

  modport source (output valid, output out_left, output out_right, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_left, input out_right, input last_of_run,
                  output ready);
endinterface

// ----- rtl/lirs_mac.sv -----
// ---------------------------------------------------------------------------
// lirs_mac
// Bit-serial interpolator: prev + floor((cur - prev) * frac / 2^16),
// one fraction bit per shift.
// ---------------------------------------------------------------------------
module lirs_mac import lirs_pkg::*; (
  input  logic              clk,
  input  mac_ctrl_t         ctrl,
  input  sample_t           prev_in,
  input  sample_t           cur_in,
  input  logic [FRAC_W-1:0] frac_in,
  output sample_t           sample_out
);

  logic signed [SAMPLE_W:0]   diff_r, diff_nxt;
  sample_t                    base_r, base_nxt;
  logic signed [SAMPLE_W+1:0] hi_r, hi_nxt;
  logic [FRAC_W-1:0]          lo_r, lo_nxt;
  logic signed [SAMPLE_W+1:0] sum;

  always_comb begin
    sum      = hi_r + (lo_r[0] ? {diff_r[SAMPLE_W], diff_r} : '0);
    diff_nxt = diff_r;
    base_nxt = base_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (ctrl.start) begin
      diff_nxt = {cur_in[SAMPLE_W-1], cur_in} - {prev_in[SAMPLE_W-1], prev_in};
      base_nxt = prev_in;
      hi_nxt   = '0;
      lo_nxt   = frac_in;
    end else if (ctrl.shift) begin
      // shift the partial product right, arithmetic on the high half
      hi_nxt = {sum[SAMPLE_W+1], sum[SAMPLE_W+1:1]};
      lo_nxt = {sum[0], lo_r[FRAC_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    base_r <= base_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
  end

  // high half is the floored quotient; the result always lies between prev and cur
  assign sample_out = base_r + hi_r[SAMPLE_W-1:0];

endmodule

// ----- rtl/linear_interp_resampler.sv -----
// ---------------------------------------------------------------------------
// linear_interp_resampler
// Stereo linear-interpolation resampler with a programmable phase step.
// ---------------------------------------------------------------------------
// Each accepted source frame yields zero to 64 output frames. The first frame
// after reset or after any register write only loads the previous-frame
// registers. For later frames, while the Q5.16 phase is below one, the block
// emits prev + floor((cur - prev) * phase / 2^16) per channel and adds
// step_q16 to the phase; then it drops one from the phase and keeps the frame
// as the previous one. Both channels go through bit-serial multipliers that
// take one phase bit per cycle; each output frame takes one load, sixteen
// multiply steps and one hand-off to the output register, which waits until
// that register is free. A frame with results holds the input side until its
// last result is handed off; a priming frame or a frame that yields no result
// leaves the input side ready. The last result of a frame waits in the output
// register while the next frame is accepted. Registers (APB, word aligned):
// step_q16 at 0x0, clamped on write to 1024..1048576, and mono_source at 0x4,
// which copies the left sample to the right one. Write only while idle.
// ---------------------------------------------------------------------------
module linear_interp_resampler import lirs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  lirs_in_if.sink           in_bus,
  lirs_out_if.source        out_bus,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;  // take a frame
  localparam logic [1:0] ST_START = 2'd1;  // load the multipliers
  localparam logic [1:0] ST_MUL   = 2'd2;  // one phase bit per cycle
  localparam logic [1:0] ST_PUT   = 2'd3;  // move the pair into the output register

  localparam logic [3:0] MUL_LAST = 4'(FRAC_W - 1);

  logic [1:0]         state_r, state_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [PHASE_W-1:0] step_r, step_nxt;
  logic               mono_r, mono_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               primed_r, primed_nxt;
  sample_t            prev_left_r, prev_left_nxt;
  sample_t            prev_right_r, prev_right_nxt;
  sample_t            cur_left_r, cur_left_nxt;
  sample_t            cur_right_r, cur_right_nxt;
  logic               out_valid_r, out_valid_nxt;
  sample_t            out_left_r, out_left_nxt;
  sample_t            out_right_r, out_right_nxt;
  logic               out_last_r, out_last_nxt;

  mac_ctrl_t          mac_ctrl;
  sample_t            mac_left, mac_right;
  sample_t            src_right;
  logic [PHASE_W-1:0] phase_sum;
  logic               phase_ge_one;
  logic               sum_ge_one;
  logic               in_beat;
  logic               cfg_wr;
  logic               out_free;
  logic               put_beat;

  // ---------------------------------------------------------------- datapath
  lirs_mac u_mac_left (
    .clk        (clk),
    .ctrl       (mac_ctrl),
    .prev_in    (prev_left_r),
    .cur_in     (cur_left_r),
    .frac_in    (phase_r[FRAC_W-1:0]),
    .sample_out (mac_left)
  );

  lirs_mac u_mac_right (
    .clk        (clk),
    .ctrl       (mac_ctrl),
    .prev_in    (prev_right_r),
    .cur_in     (cur_right_r),
    .frac_in    (phase_r[FRAC_W-1:0]),
    .sample_out (mac_right)
  );

  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_beat      = in_bus.valid && in_bus.ready;
  assign cfg_wr       = psel && penable && pwrite;
  assign src_right    = mono_r ? in_bus.left_sample : in_bus.right_sample;

  // phase + step never wraps: phase < 1.0 here and step <= 16.0
  assign phase_sum    = phase_r + step_r;
  assign phase_ge_one = (phase_r[PHASE_W-1:FRAC_W] != '0);
  assign sum_ge_one   = (phase_sum[PHASE_W-1:FRAC_W] != '0);

  // output register frees up when empty or drained in this cycle
  assign out_free = !out_valid_r || out_bus.ready;
  assign put_beat = (state_r == ST_PUT) && out_free;

  assign mac_ctrl.start = (state_r == ST_START);
  assign mac_ctrl.shift = (state_r == ST_MUL);

  // --------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    step_nxt       = step_r;
    mono_nxt       = mono_r;
    phase_nxt      = phase_r;
    primed_nxt     = primed_r;
    prev_left_nxt  = prev_left_r;
    prev_right_nxt = prev_right_r;
    cur_left_nxt   = cur_left_r;
    cur_right_nxt  = cur_right_r;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_bus.ready ? 1'b0 : out_valid_r;

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          if (!primed_r) begin
            // first frame: load history only
            prev_left_nxt  = in_bus.left_sample;
            prev_right_nxt = src_right;
            primed_nxt     = 1'b1;
          end else if (phase_ge_one) begin
            // no output point inside this interval: advance and drop
            phase_nxt      = phase_r - ONE_Q16;
            prev_left_nxt  = in_bus.left_sample;
            prev_right_nxt = src_right;
          end else begin
            cur_left_nxt  = in_bus.left_sample;
            cur_right_nxt = src_right;
            state_nxt     = ST_START;
          end
        end
      end
      ST_START: begin
        cnt_nxt   = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: begin
        if (put_beat) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = mac_left;
          out_right_nxt = mac_right;
          out_last_nxt  = sum_ge_one;
          if (sum_ge_one) begin
            // run is over: drop one whole frame and keep the current one
            phase_nxt      = phase_sum - ONE_Q16;
            prev_left_nxt  = cur_left_r;
            prev_right_nxt = cur_right_r;
            state_nxt      = ST_IDLE;
          end else begin
            phase_nxt = phase_sum;
            state_nxt = ST_START;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register write: update and restart the stream
    if (cfg_wr) begin
      if (paddr[2] == REG_STEP) begin
        step_nxt = clamp_step(pwdata[PHASE_W-1:0]);
      end else begin
        mono_nxt = pwdata[0];
      end
      phase_nxt      = '0;
      primed_nxt     = 1'b0;
      prev_left_nxt  = '0;
      prev_right_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      step_r       <= STEP_RESET;
      mono_r       <= 1'b0;
      phase_r      <= '0;
      primed_r     <= 1'b0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      step_r       <= step_nxt;
      mono_r       <= mono_nxt;
      phase_r      <= phase_nxt;
      primed_r     <= primed_nxt;
      prev_left_r  <= prev_left_nxt;
      prev_right_r <= prev_right_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    cur_left_r  <= cur_left_nxt;
    cur_right_r <= cur_right_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_last_r  <= out_last_nxt;
  end

  // ----------------------------------------------------------------- outputs
  assign out_bus.valid       = out_valid_r;
  assign out_bus.out_left    = out_left_r;
  assign out_bus.out_right   = out_right_r;
  assign out_bus.last_of_run = out_last_r;

  // register readback; zero-extend to the bus width
  always_comb begin
    if (paddr[2] == REG_MONO) begin
      prdata = {{(DATA_W-1){1'b0}}, mono_r};
    end else begin
      prdata = {{(DATA_W-PHASE_W){1'b0}}, step_r};
    end
  end

  assign pready = 1'b1;

endmodule

// ----- rtl/lirs_checker.sv -----
// ---------------------------------------------------------------------------
// lirs_checker
// Port-level checks of the resampler, bound to the top level.
// ---------------------------------------------------------------------------
`include "linear_interp_resampler_defines.svh"

module lirs_checker import lirs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input sample_t           out_left,
  input sample_t           out_right,
  input logic              out_last,
  input logic              psel,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] prdata
);

  logic out_stall;
  logic step_read;
  logic step_ok;

  assign out_stall = out_valid && !out_ready;
  assign step_read = psel && !pwrite && (paddr[2] == REG_STEP);
  assign step_ok   = (prdata[PHASE_W-1:0] >= STEP_MIN) &&
                     (prdata[PHASE_W-1:0] <= STEP_MAX) &&
                     (prdata[DATA_W-1:PHASE_W] == '0);

  // hold a stalled beat
  `LIRS_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid)
  `LIRS_ASSERT_NXT(a_out_stable, clk, rst_n, out_stall, $stable({out_left, out_right, out_last}))

  // reset empties the output register
  `LIRS_ASSERT_NXT_RST(a_rst_empty, clk, !rst_n, !out_valid)

  // step readback always sits inside the clamp window
  `LIRS_ASSERT_IMP(a_step_range, clk, rst_n, step_read, step_ok)

endmodule

bind linear_interp_resampler lirs_checker u_lirs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_left  (out_bus.out_left),
  .out_right (out_bus.out_right),
  .out_last  (out_bus.last_of_run),
  .psel      (psel),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .prdata    (prdata)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - linear_interp_resampler testbench
// Drive source frames through the resampler under random back-pressure and
// gaps on both channels. Predict every interpolated output frame and check
// each one, field by field, against the oldest prediction still owed.
// Sweep the step register from its lower clamp to its upper clamp, both
// mono and stereo, and read back every register after writing it.
// ---------------------------------------------------------------------------
module tb;
  import lirs_pkg::*;

  // Cap the run well above the slowest legal case: every frame yielding 64
  // outputs, plus the longest sink stall on every beat.
  localparam int CYCLE_LIMIT = 6_000_000;
  // Give a frame that yields no output time to leave the block before a
  // register write.
  localparam int QUIET_CYCLES = 32;

  // One source frame waiting for the driver.
  typedef struct packed {
    sample_t left_s;
    sample_t right_s;
    logic    drain_first;  // hold this beat until every owed output has come
  } src_frame_t;

  // One predicted output frame.
  typedef struct packed {
    sample_t left_s;
    sample_t right_s;
    logic    last_run;
  } out_frame_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lirs_in_if  in_if ();
  lirs_out_if out_if ();

  linear_interp_resampler dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Resampler shadow: register copies and interpolation state.
  logic [PHASE_W-1:0] step_cfg;
  logic               mono_cfg;
  logic [PHASE_W-1:0] phase_acc;
  sample_t            hist_l;
  sample_t            hist_r;
  logic               primed;

  src_frame_t frames_pending[$];   // source frames not yet driven
  out_frame_t expected_frames[$];  // output frames predicted, not yet seen
  int         frames_owed;         // size of expected_frames, registered

  logic idle_on;     // allow gaps and stalls in the current setting
  int   gap_left;
  int   stall_left;
  int   cycles;
  int   errors;
  int   frames_sent;
  int   frames_checked;
  int   cfg_writes;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  // Interpolate between two samples at a Q5.16 fraction below one. The
  // product is floored, so round toward minus infinity on negative slopes.
  function automatic sample_t interp(sample_t a, sample_t b, logic [PHASE_W-1:0] frac);
    int     span;
    longint prod;
    span = int'(a);
    span = int'(b) - span;
    prod = longint'(span) * longint'(frac);
    return sample_t'(int'(a) + int'(prod >>> FRAC_W));
  endfunction

  // Advance the shadow by one accepted source frame and queue the output
  // frames it yields.
  function automatic void resample_frame(sample_t l_in, sample_t r_in);
    sample_t    cur_r;
    out_frame_t rec;
    int         n;
    // In mono mode the right input is don't-care: copy left over it.
    cur_r = mono_cfg ? l_in : r_in;
    // First frame after reset or a register write only loads history.
    if (!primed) begin
      hist_l = l_in;
      hist_r = cur_r;
      primed = 1'b1;
      return;
    end
    n = 0;
    // Emit while the phase is below one; a phase already at or above one
    // yields nothing, but still drops by one below.
    while (phase_acc < ONE_Q16 && n < 64) begin
      rec.left_s  = interp(hist_l, l_in, phase_acc);
      rec.right_s = interp(hist_r, cur_r, phase_acc);
      n++;
      phase_acc = phase_acc + step_cfg;
      rec.last_run = !(phase_acc < ONE_Q16 && n < 64);
      expected_frames.push_back(rec);
    end
    phase_acc = phase_acc - ONE_Q16;
    hist_l = l_in;
    hist_r = cur_r;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Favor full-scale values so the multiply sees its extremes often.
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 11))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic void queue_frame(sample_t l, sample_t r, logic drain);
    src_frame_t f;
    f.left_s      = l;
    f.right_s     = r;
    f.drain_first = drain;
    frames_pending.push_back(f);
  endfunction

  // -------------------------------------------------------------------------
  // Source driver: present the next pending frame once the slot is free,
  // then hold off for a random gap.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : source_drive
    src_frame_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (frames_pending.size() != 0 &&
                   !(frames_pending[0].drain_first &&
                     (in_if.valid || frames_owed != 0))) begin
        nxt = frames_pending.pop_front();
        in_if.valid        <= 1'b1;
        in_if.left_sample  <= nxt.left_s;
        in_if.right_sample <= nxt.right_s;
        gap_left = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sink: drop ready for random stalls, short mostly, long sometimes.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 4) == 0) stall_left = pick_gap();
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: predict on every accepted source beat, check every accepted
  // output beat. Both in one block so the queue order never races.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : frame_check
    out_frame_t got;
    out_frame_t want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        resample_frame(in_if.left_sample, in_if.right_sample);
        frames_sent++;
      end
      if (out_if.valid && out_if.ready) begin
        got.left_s   = out_if.out_left;
        got.right_s  = out_if.out_right;
        got.last_run = out_if.last_of_run;
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected output beat L=%0d R=%0d last=%0b",
                   $time, got.left_s, got.right_s, got.last_run);
          errors++;
        end else begin
          want = expected_frames.pop_front();
          frames_checked++;
          if (got !== want) begin
            $display("%0t: mismatch: want L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                     $time, want.left_s, want.right_s, want.last_run,
                     got.left_s, got.right_s, got.last_run);
            errors++;
          end
        end
      end
    end
    frames_owed <= expected_frames.size();
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Configuration and sequencing
  // -------------------------------------------------------------------------

  // Wait until every frame is driven and accepted and every owed output has
  // come, then let a frame with no output clear the block.
  task automatic settle();
    do @(negedge clk);
    while (frames_pending.size() != 0 || in_if.valid || frames_owed != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // APB write: setup beat, then access beat until pready. Mirror the write
  // in the shadow once it lands; any write clears the interpolation state.
  // Then read the register back and compare it with the shadow.
  task automatic program_reg(input logic reg_sel, input logic [DATA_W-1:0] value);
    logic [PHASE_W-1:0] raw;
    logic [DATA_W-1:0]  got_rd;
    logic [DATA_W-1:0]  want_rd;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_STEP) begin
      raw = value[PHASE_W-1:0];
      step_cfg = (raw < STEP_MIN) ? STEP_MIN : (raw > STEP_MAX) ? STEP_MAX : raw;
    end else begin
      mono_cfg = value[0];
    end
    phase_acc = '0;
    hist_l    = '0;
    hist_r    = '0;
    primed    = 1'b0;
    cfg_writes++;

    // Read back: setup beat, access beat, sample prdata on the access edge.
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    got_rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    want_rd = (reg_sel == REG_STEP) ? DATA_W'(step_cfg) : DATA_W'(mono_cfg);
    if (got_rd !== want_rd) begin
      $display("%0t: readback mismatch: expected %0h, got %0h",
               $time, want_rd, got_rd);
      errors++;
    end
  endtask

  initial begin : stimulus
    int unsigned step_plan [15];
    int          frame_plan [15];
    int          p;
    int          i;

    // Hold every input at a known value from time zero.
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.left_sample  = '0;
    in_if.right_sample = '0;
    out_if.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    idle_on            = 1'b0;
    frames_owed        = 0;
    cycles             = 0;
    errors             = 0;
    frames_sent        = 0;
    frames_checked     = 0;
    cfg_writes         = 0;
    step_cfg           = STEP_RESET;
    mono_cfg           = 1'b0;
    phase_acc          = '0;
    hist_l             = '0;
    hist_r             = '0;
    primed             = 1'b0;

    // Random settings: the clamp edges, around unity, common audio rates,
    // one free pick, and raw writes on either side of the legal range.
    // Keep the slow, many-output settings short.
    step_plan  = '{1024, 1025, 10922, 15052, 30105, 60211, 65535, 65536, 65537,
                   131072, 1048575, 1048576, 0, 0, 0};
    frame_plan = '{6, 6, 30, 25, 25, 30, 30, 30, 30, 30, 30, 30, 30, 6, 30};
    step_plan[12] = $urandom_range(4096, 1048576);
    step_plan[13] = $urandom_range(0, 1023);
    step_plan[14] = $urandom_range(1048577, 21'h1FFFFF);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values, no idling: unity step, so every frame after the priming
    // one yields exactly one beat equal to the previous frame.
    @(negedge clk);
    queue_frame(16'sh7FFF, 16'sh8000, 1'b0);
    queue_frame(16'sh8000, 16'sh7FFF, 1'b0);
    queue_frame(16'sh0000, 16'shFFFF, 1'b0);
    queue_frame(16'shFFFF, 16'sh0000, 1'b0);
    settle();

    // Step written as zero clamps to the minimum: 64 beats per frame, swung
    // full scale in both directions.
    program_reg(REG_STEP, '0);
    @(negedge clk);
    queue_frame(16'sh8000, 16'sh7FFF, 1'b0);
    queue_frame(16'sh7FFF, 16'sh8000, 1'b0);
    queue_frame(16'sh8000, 16'sh7FFF, 1'b0);
    settle();

    // Step above range clamps to the maximum: after one beat the phase sits
    // at or above one for fifteen frames. Mono on, so right inputs are noise.
    program_reg(REG_STEP, DATA_W'(21'h1FFFFF));
    program_reg(REG_MONO, DATA_W'(1));
    idle_on = 1'b1;
    @(negedge clk);
    for (i = 0; i < 18; i++) begin
      queue_frame(i[0] ? 16'sh7FFF : 16'sh8000, rand_sample(), 1'b0);
    end

    // Random part: one register setting per entry, random content, idling
    // switched off for some settings.
    for (p = 0; p < 15; p++) begin
      settle();
      program_reg(REG_STEP, DATA_W'(step_plan[p]));
      program_reg(REG_MONO, DATA_W'($urandom_range(0, 1)));
      idle_on = ($urandom_range(0, 3) != 0);
      @(negedge clk);
      for (i = 0; i < frame_plan[p]; i++) begin
        // Now and then, and at least once, drain all outputs before a beat.
        queue_frame(rand_sample(), rand_sample(),
                    (p == 2 && i == 4) || ($urandom_range(0, 49) == 0));
      end
    end

    settle();
    $display("tb: %0d source frames and %0d checked output frames over %0d register writes",
             frames_sent, frames_checked, cfg_writes);
    $display("tb: steps from the lower to the upper clamp, mono and stereo, with stalls");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
